// ===== hw/rtl/pst_pkg.sv =====
// Shared types and constants for the point set table.
// Used by pst_front, pst_queue, pst_back and point_set_table; depends on nothing.
package pst_pkg;

   // Table size and derived widths
   localparam int CAPACITY    = 64;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);

   // Field widths on the streams
   localparam int COORD_W     = 32;
   localparam int KEY_W       = 2 * COORD_W;
   localparam int TRIM_W      = 7;
   localparam int KIND_W      = 2;
   localparam int STAT_W      = 2;
   localparam int POS_W       = 6;
   localparam int OCC_W       = 7;
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 16;

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [KIND_W-1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_LOOKUP = 2'd2,
      REQ_TRIM   = 2'd3
   } req_kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE    = 2'd0,
      STAT_PRESENT = 2'd1,
      STAT_ABSENT  = 2'd2,
      STAT_FULL    = 2'd3
   } status_type;

   // One classified request: key is {x, y}
   typedef struct packed {
      req_kind_type           kind;
      logic [KEY_W-1:0]       key;
      logic [TRIM_W-1:0]      trim;
   } op_type;

   // One result
   typedef struct packed {
      status_type             status;
      logic [POS_W-1:0]       position;
      logic [OCC_W-1:0]       occupancy;
   } rsp_type;

endpackage

// ===== hw/rtl/pst_front.sv =====
// Front end of the point set table: unpacks and classifies incoming requests.
// Depends on pst_pkg; feeds pst_queue.
module pst_front (
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [pst_pkg::KIND_W-1:0]  req_tuser,
   input  logic [pst_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                        push_valid,
   input  logic                        push_ready,
   output pst_pkg::op_type             push_op
);

   logic [pst_pkg::COORD_W-1:0] coord_x;
   logic [pst_pkg::COORD_W-1:0] coord_y;
   logic [pst_pkg::TRIM_W-1:0]  trim_count;
   pst_pkg::req_kind_type       kind;

   // Unpack fields
   assign coord_x    = req_tdata[pst_pkg::COORD_W-1:0];
   assign coord_y    = req_tdata[2*pst_pkg::COORD_W-1:pst_pkg::COORD_W];
   assign trim_count = req_tdata[2*pst_pkg::COORD_W +: pst_pkg::TRIM_W];
   assign kind       = pst_pkg::req_kind_type'(req_tuser);

   // Classify: a trim carries only its count, a point request only its key
   always_comb begin
      push_op.kind = kind;
      if (kind == pst_pkg::REQ_TRIM) begin
         push_op.key  = '0;
         push_op.trim = trim_count;
      end else begin
         push_op.key  = {coord_x, coord_y};
         push_op.trim = '0;
      end
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

// ===== hw/rtl/pst_queue.sv =====
// Short request queue that decouples the front end from the table engine.
// Depends on pst_pkg.
module pst_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  pst_pkg::op_type  push_op,
   output logic             pop_valid,
   input  logic             pop_ready,
   output pst_pkg::op_type  pop_op
);

   pst_pkg::op_type             entry_ff [pst_pkg::QUEUE_DEPTH];
   logic [pst_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [pst_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [pst_pkg::QCNT_W-1:0]  fill_ff, fill_in;
   logic                        do_push;
   logic                        do_pop;

   assign push_ready = (fill_ff != pst_pkg::QCNT_W'(pst_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_op     = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store pushed requests
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== hw/rtl/pst_back.sv =====
// Table engine of the point set table: point memory, linear search, shift-down
// on remove, trim, and the result register. Depends on pst_pkg.
module pst_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  pst_pkg::op_type               pop_op,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pst_pkg::STAT_W-1:0]    rsp_tuser,
   output logic [pst_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT
   } state_type;

   state_type                    state_ff, state_in;
   pst_pkg::op_type              op_ff, op_in;
   logic [pst_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [pst_pkg::CNT_W-1:0]    scan_ff, scan_in;
   logic                         pend_ff, pend_in;
   logic [pst_pkg::IDX_W-1:0]    pend_idx_ff, pend_idx_in;
   logic [pst_pkg::IDX_W-1:0]    match_idx_ff, match_idx_in;
   logic                         rsp_vld_ff, rsp_vld_in;
   pst_pkg::rsp_type             rsp_ff, rsp_in;
   logic [pst_pkg::KEY_W-1:0]    rd_data_ff;

   logic [pst_pkg::KEY_W-1:0]    point_mem [pst_pkg::CAPACITY];
   logic                         mem_we;
   logic [pst_pkg::IDX_W-1:0]    mem_waddr;
   logic [pst_pkg::KEY_W-1:0]    mem_wdata;
   logic                         mem_re;
   logic [pst_pkg::IDX_W-1:0]    mem_raddr;

   logic                         slot_free;
   logic                         hit;
   logic                         more;
   logic                         is_full;

   assign slot_free = !rsp_vld_ff || rsp_tready;
   assign pop_ready = (state_ff == S_IDLE) && slot_free;
   assign hit       = pend_ff && (rd_data_ff == op_ff.key);
   assign more      = (scan_ff < count_ff);
   assign is_full   = (count_ff == pst_pkg::CNT_W'(pst_pkg::CAPACITY));

   // Sequence search, shift and trim; load the result register on completion
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      match_idx_in = match_idx_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = pend_idx_ff;
      mem_wdata    = rd_data_ff;
      mem_re       = 1'b0;
      mem_raddr    = scan_ff[pst_pkg::IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (pop_valid && pop_ready) begin
               op_in = pop_op;
               if (pop_op.kind == pst_pkg::REQ_TRIM) begin
                  // Drop the tail, saturating at empty
                  if (32'(pop_op.trim) >= 32'(count_ff)) begin
                     count_in = '0;
                  end else begin
                     count_in = count_ff - pst_pkg::CNT_W'(pop_op.trim);
                  end
                  rsp_vld_in         = 1'b1;
                  rsp_in.status      = pst_pkg::STAT_DONE;
                  rsp_in.position    = '0;
                  rsp_in.occupancy   = pst_pkg::OCC_W'(count_in);
               end else begin
                  state_in = S_SEARCH;
                  scan_in  = '0;
                  pend_in  = 1'b0;
               end
            end
         end

         S_SEARCH: begin
            pend_in = 1'b0;
            if (hit) begin
               match_idx_in = pend_idx_ff;
               if (op_ff.kind == pst_pkg::REQ_REMOVE) begin
                  // Start moving later entries down one place
                  state_in = S_SHIFT;
                  scan_in  = pst_pkg::CNT_W'(pend_idx_ff) + 1'b1;
               end else begin
                  state_in         = S_IDLE;
                  rsp_vld_in       = 1'b1;
                  rsp_in.status    = (op_ff.kind == pst_pkg::REQ_ADD) ?
                                     pst_pkg::STAT_PRESENT : pst_pkg::STAT_DONE;
                  rsp_in.position  = pst_pkg::POS_W'(pend_idx_ff);
                  rsp_in.occupancy = pst_pkg::OCC_W'(count_ff);
               end
            end else if (more) begin
               // Read the next entry; compare it next cycle
               mem_re      = 1'b1;
               mem_raddr   = scan_ff[pst_pkg::IDX_W-1:0];
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[pst_pkg::IDX_W-1:0];
               scan_in     = scan_ff + 1'b1;
            end else begin
               // No match anywhere
               state_in         = S_IDLE;
               rsp_vld_in       = 1'b1;
               rsp_in.position  = '0;
               rsp_in.occupancy = pst_pkg::OCC_W'(count_ff);
               if (op_ff.kind == pst_pkg::REQ_ADD) begin
                  if (is_full) begin
                     rsp_in.status = pst_pkg::STAT_FULL;
                  end else begin
                     mem_we           = 1'b1;
                     mem_waddr        = count_ff[pst_pkg::IDX_W-1:0];
                     mem_wdata        = op_ff.key;
                     count_in         = count_ff + 1'b1;
                     rsp_in.status    = pst_pkg::STAT_DONE;
                     rsp_in.position  = pst_pkg::POS_W'(count_ff);
                     rsp_in.occupancy = pst_pkg::OCC_W'(count_in);
                  end
               end else begin
                  rsp_in.status = pst_pkg::STAT_ABSENT;
               end
            end
         end

         S_SHIFT: begin
            // Write back the entry read last cycle one place lower
            mem_we    = pend_ff;
            mem_waddr = pend_idx_ff;
            mem_wdata = rd_data_ff;
            if (more) begin
               mem_re      = 1'b1;
               mem_raddr   = scan_ff[pst_pkg::IDX_W-1:0];
               pend_in     = 1'b1;
               pend_idx_in = pst_pkg::IDX_W'(scan_ff - 1'b1);
               scan_in     = scan_ff + 1'b1;
            end else begin
               pend_in          = 1'b0;
               state_in         = S_IDLE;
               count_in         = count_ff - 1'b1;
               rsp_vld_in       = 1'b1;
               rsp_in.status    = pst_pkg::STAT_DONE;
               rsp_in.position  = pst_pkg::POS_W'(match_idx_ff);
               rsp_in.occupancy = pst_pkg::OCC_W'(count_in);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         pend_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         pend_ff    <= pend_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Hold working payload
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      scan_ff      <= scan_in;
      pend_idx_ff  <= pend_idx_in;
      match_idx_ff <= match_idx_in;
      rsp_ff       <= rsp_in;
   end

   // Point memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         point_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= point_mem[mem_raddr];
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = pst_pkg::RSP_DATA_W'({rsp_ff.occupancy, rsp_ff.position});

endmodule

// ===== hw/rtl/point_set_table.sv =====
// Point set table top level: front end, request queue and table engine.
// Depends on pst_pkg, pst_front, pst_queue and pst_back.
//
//  Channel | Ports        | tuser (low bit up) | tdata (low bit up)
//  --------+--------------+--------------------+--------------------------------------
//  request | req_t*       | req_type[1:0]      | coord_x[31:0], coord_y[63:32],
//          |              |                    | trim_count[70:64], zero[71]
//  result  | rsp_t*       | status[1:0]        | position[5:0], occupancy[12:6],
//          |              |                    | zero[15:13]
//
// A trim completes in the engine without a search. Add and lookup run a linear
// search at one memory read per cycle. A remove adds a shift-down of the later
// entries through the same memory port. Reset is synchronous and empties the
// table at once; no clearing pass. A two-entry queue keeps accepting requests,
// until both entries are full, while the engine works or a result waits in its
// output register.
module point_set_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pst_pkg::KIND_W-1:0]      req_tuser,  // req_type
   input  logic [pst_pkg::REQ_DATA_W-1:0]  req_tdata,  // coord_x, coord_y, trim_count
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pst_pkg::STAT_W-1:0]      rsp_tuser,  // status
   output logic [pst_pkg::RSP_DATA_W-1:0]  rsp_tdata   // position, occupancy
);

   logic             push_valid;
   logic             push_ready;
   pst_pkg::op_type  push_op;
   logic             pop_valid;
   logic             pop_ready;
   pst_pkg::op_type  pop_op;

   pst_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op)
   );

   pst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   pst_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
